// ===== hdl/skns_pkg.sv =====
// Package with shared widths, operation codes and status codes for the sorted key search.
package skns_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int KEY_WIDTH           = 32;
   localparam int HINT_WIDTH          = 8;
   localparam int OP_WIDTH            = 2;
   localparam int MODE_WIDTH          = 2;
   localparam int STATUS_WIDTH        = 3;
   localparam int REQ_TDATA_WIDTH     = 80;
   localparam int RSP_TDATA_WIDTH     = 32;

   localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_QUERY  = 2'd2;

   localparam logic [MODE_WIDTH-1:0] MODE_FLOOR   = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_CEILING = 2'd1;

   localparam logic [STATUS_WIDTH-1:0] ST_ACK   = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EXACT = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_PICK  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 3'd4;

endpackage

// ===== hdl/skns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module skns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sorted_key_nearest_search.sv =====
// Top level of the sorted key table with floor, ceiling and nearest search.
//
//   channel | direction | tdata                                   | tuser
//   req     | in        | key_value, target_key, hint, closeness  | op
//   rsp     | out       | found_key                               | status
//
// Clear, append, an unused op and a query on an empty table are answered from S_IDLE.
// Another query passes S_HINT and S_FIRST, then walks through the key RAM in S_WALK,
// one RAM read per cycle.
// A result waits in the output register; req_tready is low while a query walks.
// Synchronous reset empties the table at once; the RAM contents are not cleared.
module sorted_key_nearest_search #(
   parameter int TABLE_DEPTH = skns_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // key_value[31:0], target_key[63:32], hint_fraction[71:64], closeness[73:72], zeros
   input  logic [skns_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // op[1:0]
   input  logic [skns_pkg::OP_WIDTH-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found_key[31:0]
   output logic [skns_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // status[2:0]
   output logic [skns_pkg::STATUS_WIDTH-1:0]    rsp_tuser
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = skns_pkg::KEY_WIDTH;
   localparam int HW = skns_pkg::HINT_WIDTH;
   localparam int MW = skns_pkg::MODE_WIDTH;
   localparam int SW = skns_pkg::STATUS_WIDTH;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HINT  = 2'd1;
   localparam logic [1:0] S_FIRST = 2'd2;
   localparam logic [1:0] S_WALK  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] last_key_ff, last_key_in;
   logic [KW-1:0] target_ff, target_in;
   logic [MW-1:0] mode_ff, mode_in;
   logic [HW-1:0] hint_ff, hint_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          up_ff, up_in;
   logic [KW-1:0] prev_ff, prev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [KW-1:0] rsp_key_ff, rsp_key_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;

   logic                         req_fire;
   logic [skns_pkg::OP_WIDTH-1:0] req_op;
   logic [KW-1:0]                req_key;
   logic [KW-1:0]                req_target;
   logic [HW-1:0]                req_hint;
   logic [MW-1:0]                req_mode;

   logic          wr_en;
   logic [KW-1:0] rd_data;
   logic [AW-1:0] last_idx;
   logic [CW+HW-1:0] hint_prod;
   logic [CW-1:0] hint_idx;
   logic          rd_eq;
   logic          rd_lt;
   logic          at_end;
   logic [KW-1:0] lo_key;
   logic [KW-1:0] hi_key;
   logic [KW:0]   d_hi;
   logic [KW:0]   d_lo;
   logic [KW-1:0] pick_key;

   assign req_op     = req_tuser;
   assign req_key    = req_tdata[KW-1:0];
   assign req_target = req_tdata[2*KW-1:KW];
   assign req_hint   = req_tdata[2*KW+HW-1:2*KW];
   assign req_mode   = req_tdata[2*KW+HW+MW-1:2*KW+HW];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign wr_en = req_fire && (req_op == skns_pkg::OP_APPEND) &&
                  (count_ff < CW'(TABLE_DEPTH)) &&
                  ((count_ff == '0) || ($signed(req_key) > $signed(last_key_ff)));

   assign last_idx  = AW'(count_ff - CW'(1));
   assign hint_prod = (CW+HW)'(count_ff) * (CW+HW)'(hint_ff);
   assign rd_eq     = (rd_data == target_ff);
   assign rd_lt     = $signed(rd_data) < $signed(target_ff);
   assign lo_key    = up_ff ? prev_ff : rd_data;
   assign hi_key    = up_ff ? rd_data : prev_ff;
   assign d_hi      = {hi_key[KW-1], hi_key} - {target_ff[KW-1], target_ff};
   assign d_lo      = {target_ff[KW-1], target_ff} - {lo_key[KW-1], lo_key};

   always_comb begin
      if (hint_prod[CW+HW-1:HW] >= count_ff) begin
         hint_idx = count_ff - CW'(1);
      end else begin
         hint_idx = hint_prod[CW+HW-1:HW];
      end
   end

   always_comb begin
      unique case (mode_ff)
         skns_pkg::MODE_FLOOR: pick_key = lo_key;
         skns_pkg::MODE_CEILING: pick_key = hi_key;
         default: pick_key = ($signed(d_hi) < $signed(d_lo)) ? hi_key : lo_key;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_key_in   = last_key_ff;
      target_in     = target_ff;
      mode_in       = mode_ff;
      hint_in       = hint_ff;
      idx_in        = idx_ff;
      up_in         = up_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      at_end        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_key_in    = '0;
               rsp_status_in = skns_pkg::ST_ACK;
               rsp_valid_in  = 1'b1;
               unique case (req_op)
                  skns_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  skns_pkg::OP_APPEND: begin
                     if (wr_en) begin
                        count_in    = count_ff + CW'(1);
                        last_key_in = req_key;
                     end else if ((count_ff >= CW'(TABLE_DEPTH)) ||
                                  ($signed(req_key) < $signed(last_key_ff))) begin
                        rsp_status_in = skns_pkg::ST_FULL;
                     end
                  end
                  skns_pkg::OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = skns_pkg::ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        target_in    = req_target;
                        mode_in      = req_mode;
                        hint_in      = req_hint;
                        state_in     = S_HINT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HINT: begin
            idx_in   = hint_idx[AW-1:0];
            state_in = S_FIRST;
         end
         S_FIRST, S_WALK: begin
            at_end = (!rd_lt && (idx_ff == '0)) || (rd_lt && (idx_ff == last_idx));
            if (rd_eq) begin
               rsp_key_in    = target_ff;
               rsp_status_in = skns_pkg::ST_EXACT;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if ((state_ff == S_WALK) && (rd_lt != up_ff)) begin
               rsp_key_in    = pick_key;
               rsp_status_in = skns_pkg::ST_PICK;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (at_end) begin
               rsp_key_in    = rd_data;
               rsp_status_in = skns_pkg::ST_PICK;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               up_in    = rd_lt;
               prev_in  = rd_data;
               idx_in   = rd_lt ? idx_ff + AW'(1) : idx_ff - AW'(1);
               state_in = S_WALK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_key_ff   <= last_key_in;
      target_ff     <= target_in;
      mode_ff       <= mode_in;
      hint_ff       <= hint_in;
      idx_ff        <= idx_in;
      up_ff         <= up_in;
      prev_ff       <= prev_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

   skns_ram #(
      .WIDTH(KW),
      .DEPTH(TABLE_DEPTH)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_key),
      .rd_addr(idx_in),
      .rd_data(rd_data)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("Key count exceeds the table depth.");

   a_slot_free_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("Result register is occupied while a query is in flight.");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == skns_pkg::OP_CLEAR)) |=> (count_ff == '0))
      else $error("Clear transfer did not empty the table.");

   a_append_grows_one: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("Stored append did not advance the key count by one.");
`endif

endmodule
